// ----- rtl/xlb_pkg.sv -----
// ----------------------------------------------------------------------------
// xlb_pkg
// Shared types and constants for the xor linear basis unit: vector width,
// index widths, mode codes and the beat and control structs.
// ----------------------------------------------------------------------------
package xlb_pkg;

   localparam int WIDTH  = 64;
   localparam int IDX_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int RANK_W = $clog2(WIDTH + 1);

   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_QUERY    = 2'd1;
   localparam logic [1:0] MODE_MAXIMIZE = 2'd2;
   localparam logic [1:0] MODE_CLEAR    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] vec;
   } xlb_req_type;

   typedef struct packed {
      logic        added;
      logic        in_span;
      logic [63:0] coords;
      logic [63:0] best;
      logic [6:0]  rank_now;
   } xlb_rsp_type;

   // update request from the sequencer to the basis bookkeeping
   typedef struct packed {
      logic             clear;
      logic             set_pivot;
      logic [IDX_W-1:0] pivot_idx;
      logic             acc_en;
      logic [WIDTH-1:0] acc_val;
   } xlb_trk_cmd_type;

   typedef struct packed {
      logic [WIDTH-1:0]  pivots;
      logic [RANK_W-1:0] rank;
      logic [WIDTH-1:0]  acc;
   } xlb_trk_state_type;

endpackage

// ----- rtl/xor_linear_basis_unit.sv -----
// ----------------------------------------------------------------------------
// xor_linear_basis_unit
// Fully reduced GF(2) linear basis of 64-bit vectors with insert, span
// query, maximize-xor and clear commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the command's result has been formed, and the result appears in
// the next cycle on rsp_item for exactly one cycle with rsp_valid high. The
// receiver cannot stall, so it must take every result beat as it comes.
// Basis rows live in a single row memory read one row per cycle. Query,
// maximize and an insert that stores nothing make a top-down scan of all
// rows and then pass through a result state; an insert that stores a new
// pivot b adds a read-modify-write walk of the rows above b after the
// scan, and clear goes straight to the result state without a scan. The
// result beat comes in the first cycle with busy low. Reset and clear
// empty the basis at once through per-row valid bits, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module xor_linear_basis_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  xlb_pkg::xlb_req_type req_item,
   output logic                 rsp_valid,
   output xlb_pkg::xlb_rsp_type rsp_item
);

   xlb_pkg::xlb_trk_cmd_type   trk_cmd;
   xlb_pkg::xlb_trk_state_type trk_state;

   logic                        rd_en;
   logic [xlb_pkg::IDX_W-1:0]   rd_addr;
   logic [xlb_pkg::WIDTH-1:0]   rd_data;
   logic                        wr_en;
   logic [xlb_pkg::IDX_W-1:0]   wr_addr;
   logic [xlb_pkg::WIDTH-1:0]   wr_data;
   logic                        done;
   xlb_pkg::xlb_rsp_type        done_item;

   logic                        rsp_valid_ff;
   xlb_pkg::xlb_rsp_type        rsp_item_ff;

   xlb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .trk_state (trk_state),
      .trk_cmd   (trk_cmd),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .done      (done),
      .done_item (done_item)
   );

   xlb_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .trk_cmd   (trk_cmd),
      .trk_state (trk_state)
   );

   xlb_row_ram #(
      .DEPTH  (xlb_pkg::WIDTH),
      .DATA_W (xlb_pkg::WIDTH),
      .ADDR_W (xlb_pkg::IDX_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register for the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_item_ff <= done_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_rank_matches_pivots : assert property (@(posedge clock) disable iff (reset)
      $countones(trk_state.pivots) == int'(trk_state.rank))
      else $error("rank out of step with pivot valid bits");

   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.mode == xlb_pkg::MODE_CLEAR) |=>
         (trk_state.rank == '0 && trk_state.acc == '0))
      else $error("clear did not empty the basis");

   a_single_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beats back to back");

   a_no_write_while_idle : assert property (@(posedge clock) disable iff (reset)
      !busy |-> !wr_en)
      else $error("row write outside a command");

endmodule

// ----- rtl/xlb_row_ram.sv -----
// ----------------------------------------------------------------------------
// xlb_row_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module xlb_row_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/xlb_tracker.sv -----
// ----------------------------------------------------------------------------
// xlb_tracker
// Basis bookkeeping: one valid bit per pivot row, the rank and the running
// xor of all stored rows.
// ----------------------------------------------------------------------------
module xlb_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  xlb_pkg::xlb_trk_cmd_type   trk_cmd,
   output xlb_pkg::xlb_trk_state_type trk_state
);

   logic [xlb_pkg::WIDTH-1:0]  pivots_ff;
   logic [xlb_pkg::RANK_W-1:0] rank_ff;
   logic [xlb_pkg::WIDTH-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      if (reset || trk_cmd.clear) begin
         pivots_ff <= '0;
         rank_ff   <= '0;
         acc_ff    <= '0;
      end else begin
         if (trk_cmd.set_pivot) begin
            pivots_ff[trk_cmd.pivot_idx] <= 1'b1;
            rank_ff                      <= rank_ff + 1'b1;
         end
         if (trk_cmd.acc_en) begin
            acc_ff <= acc_ff ^ trk_cmd.acc_val;
         end
      end
   end

   assign trk_state.pivots = pivots_ff;
   assign trk_state.rank   = rank_ff;
   assign trk_state.acc    = acc_ff;

endmodule

// ----- rtl/xlb_engine.sv -----
// ----------------------------------------------------------------------------
// xlb_engine
// Row sequencer: for all commands but clear, scans the row memory from the
// top row down, one row per cycle; a new pivot then patches the higher rows.
// ----------------------------------------------------------------------------
module xlb_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  xlb_pkg::xlb_req_type              req_item,
   output logic                              busy,
   input  xlb_pkg::xlb_trk_state_type        trk_state,
   output xlb_pkg::xlb_trk_cmd_type          trk_cmd,
   output logic                              rd_en,
   output logic [xlb_pkg::IDX_W-1:0]         rd_addr,
   input  logic [xlb_pkg::WIDTH-1:0]         rd_data,
   output logic                              wr_en,
   output logic [xlb_pkg::IDX_W-1:0]         wr_addr,
   output logic [xlb_pkg::WIDTH-1:0]         wr_data,
   output logic                              done,
   output xlb_pkg::xlb_rsp_type              done_item
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   localparam logic [xlb_pkg::IDX_W-1:0] TOP_IDX = xlb_pkg::IDX_W'(xlb_pkg::WIDTH - 1);

   state_type                   state_ff, state_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [xlb_pkg::WIDTH-1:0]   x_ff, x_in;
   logic [xlb_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [xlb_pkg::IDX_W-1:0]   b_ff, b_in;
   logic                        found_ff, found_in;
   logic                        fail_ff, fail_in;
   logic [xlb_pkg::WIDTH-1:0]   coord_ff, coord_in;

   logic                        row_valid;
   logic                        x_bit;
   logic [xlb_pkg::WIDTH-1:0]   x_step;

   assign row_valid = trk_state.pivots[idx_ff];
   assign x_bit     = x_ff[idx_ff];
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      x_in     = x_ff;
      idx_in   = idx_ff;
      b_in     = b_ff;
      found_in = found_ff;
      fail_in  = fail_ff;
      coord_in = coord_ff;
      x_step   = x_ff;
      rd_en    = 1'b0;
      rd_addr  = TOP_IDX;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = x_ff;
      trk_cmd  = '0;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_item.mode;
               x_in     = req_item.vec[xlb_pkg::WIDTH-1:0];
               idx_in   = TOP_IDX;
               found_in = 1'b0;
               fail_in  = 1'b0;
               coord_in = '0;
               if (req_item.mode == xlb_pkg::MODE_CLEAR) begin
                  trk_cmd.clear = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = TOP_IDX;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            case (mode_ff)
               xlb_pkg::MODE_INSERT: begin
                  if (x_bit) begin
                     if (row_valid) begin
                        x_step = x_ff ^ rd_data;
                     end else if (!found_ff) begin
                        found_in = 1'b1;
                        b_in     = idx_ff;
                     end
                  end
               end
               xlb_pkg::MODE_QUERY: begin
                  if (x_bit) begin
                     if (row_valid) begin
                        x_step           = x_ff ^ rd_data;
                        coord_in[idx_ff] = 1'b1;
                     end else begin
                        fail_in = 1'b1;
                     end
                  end
               end
               default: begin
                  if (!x_bit && row_valid) begin
                     x_step = x_ff ^ rd_data;
                  end
               end
            endcase
            x_in = x_step;
            if (idx_ff != '0) begin
               idx_in  = idx_ff - 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff - 1'b1;
            end else if (mode_ff == xlb_pkg::MODE_INSERT && found_in) begin
               // new pivot row goes in, then the higher rows get patched
               wr_en             = 1'b1;
               wr_addr           = b_in;
               wr_data           = x_step;
               trk_cmd.set_pivot = 1'b1;
               trk_cmd.pivot_idx = b_in;
               trk_cmd.acc_en    = 1'b1;
               trk_cmd.acc_val   = x_step;
               if (b_in == TOP_IDX) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = b_in + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = b_in + 1'b1;
                  state_in = ST_UPDATE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_UPDATE: begin
            if (row_valid && rd_data[b_ff]) begin
               wr_en           = 1'b1;
               wr_addr         = idx_ff;
               wr_data         = rd_data ^ x_ff;
               trk_cmd.acc_en  = 1'b1;
               trk_cmd.acc_val = x_ff;
            end
            if (idx_ff == TOP_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      x_ff     <= x_in;
      idx_ff   <= idx_in;
      b_ff     <= b_in;
      found_ff <= found_in;
      fail_ff  <= fail_in;
      coord_ff <= coord_in;
   end

   always_comb begin
      done_item.added    = (mode_ff == xlb_pkg::MODE_INSERT) && found_ff;
      done_item.in_span  = (mode_ff == xlb_pkg::MODE_QUERY) && !fail_ff;
      done_item.coords   = done_item.in_span ? 64'(coord_ff) : 64'd0;
      done_item.best     = (mode_ff == xlb_pkg::MODE_MAXIMIZE) ? 64'(x_ff)
                                                               : 64'(trk_state.acc);
      done_item.rank_now = 7'(trk_state.rank);
   end

endmodule

// ----- dv/xor_linear_basis_unit_tb.sv -----
// ----------------------------------------------------------------------------
// xor_linear_basis_unit_tb
// Self-checking bench for the GF(2) basis unit. A short table of directed
// commands is followed by random episodes: each one clears the basis and
// then mixes inserts, span queries, maximize and the odd clear. Vectors are
// drawn from full-width random values, small lane subspaces, single bits
// and corner values. A local model of the reduced basis predicts each
// result the table does not give; beats are checked field by field in order.
// ----------------------------------------------------------------------------
module xor_linear_basis_unit_tb;

   localparam int BEAT_TARGET = 1826;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * xlb_pkg::WIDTH + 8;
   localparam logic [63:0] VEC_MASK = {64{1'b1}} >> (64 - xlb_pkg::WIDTH);

   typedef struct {
      xlb_pkg::xlb_req_type beat;
      logic                 typed_in;
      xlb_pkg::xlb_rsp_type want;
   } table_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   xlb_pkg::xlb_req_type req_item;
   logic                 rsp_valid;
   xlb_pkg::xlb_rsp_type rsp_item;

   logic [63:0]          basis_row [64];
   logic [6:0]           pivot_total;
   xlb_pkg::xlb_rsp_type pending_rsp [$];
   xlb_pkg::xlb_rsp_type want_rsp;
   logic [63:0]          lane_mask;
   int                   burst_left;
   int                   mismatch_count = 0;
   int                   idle_cycles = 0;

   xor_linear_basis_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void basis_wipe();
      for (int i = 0; i < 64; i++) basis_row[i] = '0;
      pivot_total = '0;
   endfunction

   function automatic logic [63:0] span_xor_all();
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < xlb_pkg::WIDTH; i++) acc ^= basis_row[i];
      return acc;
   endfunction

   function automatic xlb_pkg::xlb_rsp_type basis_apply(xlb_pkg::xlb_req_type beat);
      xlb_pkg::xlb_rsp_type r;
      logic [63:0]          x;
      logic                 done;
      r = '0;
      x = beat.vec & VEC_MASK;
      done = 1'b0;
      case (beat.mode)
         xlb_pkg::MODE_INSERT: begin
            for (int i = xlb_pkg::WIDTH - 1; i >= 0; i--) begin
               if (!done && x[i]) begin
                  if (basis_row[i][i]) begin
                     x ^= basis_row[i];
                  end else begin
                     for (int j = 0; j < i; j++) if (x[j]) x ^= basis_row[j];
                     for (int j = i + 1; j < xlb_pkg::WIDTH; j++)
                        if (basis_row[j][i]) basis_row[j] ^= x;
                     basis_row[i] = x;
                     pivot_total++;
                     done = 1'b1;
                  end
               end
            end
            r.added = done;
            r.best = span_xor_all();
         end
         xlb_pkg::MODE_QUERY: begin
            r.in_span = 1'b1;
            for (int i = xlb_pkg::WIDTH - 1; i >= 0; i--) begin
               if (r.in_span && x[i]) begin
                  if (basis_row[i][i]) begin
                     r.coords[i] = 1'b1;
                     x ^= basis_row[i];
                  end else begin
                     r.in_span = 1'b0;
                  end
               end
            end
            if (!r.in_span) r.coords = '0;
            r.best = span_xor_all();
         end
         xlb_pkg::MODE_MAXIMIZE: begin
            for (int i = xlb_pkg::WIDTH - 1; i >= 0; i--) if (!x[i]) x ^= basis_row[i];
            r.best = x;
         end
         default: begin
            basis_wipe();
         end
      endcase
      r.rank_now = pivot_total;
      return r;
   endfunction

   function automatic table_row_type step_row(logic [1:0] mode, logic [63:0] vec,
                                              logic typed_in, logic added,
                                              logic in_span, logic [63:0] coords,
                                              logic [63:0] best, logic [6:0] rank_now);
      table_row_type row;
      row.beat.mode = mode;
      row.beat.vec = vec;
      row.typed_in = typed_in;
      row.want.added = added;
      row.want.in_span = in_span;
      row.want.coords = coords;
      row.want.best = best;
      row.want.rank_now = rank_now;
      return row;
   endfunction

   function automatic logic [63:0] pick_vec(int kind);
      logic [63:0] v;
      if (kind < 3) begin
         v = {$urandom, $urandom};
      end else if (kind < 7) begin
         v = {$urandom, $urandom} & lane_mask;
      end else if (kind < 9) begin
         v = 64'd1 << $urandom_range(63, 0);
      end else begin
         case ($urandom_range(3, 0))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << 63;
            default: v = 64'd1;
         endcase
      end
      return v;
   endfunction

   task automatic issue_beat(xlb_pkg::xlb_req_type beat, logic typed_in,
                             xlb_pkg::xlb_rsp_type want);
      xlb_pkg::xlb_rsp_type predicted;
      int                   gap;
      start <= 1'b1;
      req_item <= beat;
      do @(posedge clock); while (busy);
      predicted = basis_apply(beat);
      pending_rsp.push_back(typed_in ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 1) : $urandom_range(12, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(6, 0);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: added %0b in_span %0b coords %h best %h rank %0d",
                        rsp_item.added, rsp_item.in_span, rsp_item.coords,
                        rsp_item.best, rsp_item.rank_now);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_item.added !== want_rsp.added || rsp_item.in_span !== want_rsp.in_span ||
                rsp_item.coords !== want_rsp.coords || rsp_item.best !== want_rsp.best ||
                rsp_item.rank_now !== want_rsp.rank_now) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch (expected/actual): added %0b/%0b in_span %0b/%0b",
                           want_rsp.added, rsp_item.added, want_rsp.in_span,
                           rsp_item.in_span);
                  $display("   coords %h/%h best %h/%h rank %0d/%0d",
                           want_rsp.coords, rsp_item.coords, want_rsp.best,
                           rsp_item.best, want_rsp.rank_now, rsp_item.rank_now);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      table_row_type        plan [$];
      logic [63:0]          stored_vecs [$];
      xlb_pkg::xlb_req_type beat;
      int                   sent;
      int                   ep_len;
      int                   r;
      int                   kind;
      logic                 fill;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      basis_wipe();
      burst_left = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty basis, a small hand-built basis, clear, checks, clear again
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, 64'd0, 1, 0, 1, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, 64'd0, 1, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, '1, 1, 0, 0, 0, '1, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, 64'd1 << 63, 1, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'd0, 1, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, '1, 1, 1, 0, 0, '1, 1));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, '1, 1, 0, 0, 0, '1, 1));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'd1, 1, 1, 0, 0, '1, 2));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'd1 << 63, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, '1, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, 64'd1 << 63, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, 64'h5, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, 64'd0, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, 64'haaaa_aaaa_aaaa_aaaa,
                              0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'h6, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'h8000_0000_0000_0001,
                              0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'h5555_5555_5555_5555,
                              0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, 64'h5555_5555_5555_5555,
                              0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, '1, 0, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_CLEAR, 64'd0, 1, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_QUERY, '1, 1, 0, 0, 0, 0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_MAXIMIZE, 64'h1234_5678_9abc_def0, 1, 0, 0, 0,
                              64'h1234_5678_9abc_def0, 0));
      plan.push_back(step_row(xlb_pkg::MODE_INSERT, 64'd1 << 63, 1, 1, 0, 0,
                              64'd1 << 63, 1));
      plan.push_back(step_row(xlb_pkg::MODE_CLEAR, '1, 1, 0, 0, 0, 0, 0));
      foreach (plan[n]) issue_beat(plan[n].beat, plan[n].typed_in, plan[n].want);

      // random episodes, each opened by a clear; fill episodes seek full rank
      while (sent < BEAT_TARGET) begin
         fill = ($urandom_range(3, 0) == 0);
         ep_len = fill ? $urandom_range(110, 80) : $urandom_range(60, 10);
         lane_mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         stored_vecs.delete();
         beat.mode = xlb_pkg::MODE_CLEAR;
         beat.vec = {$urandom, $urandom};
         issue_beat(beat, 1'b0, '0);
         sent++;
         for (int k = 0; k < ep_len && sent < BEAT_TARGET; k++) begin
            r = $urandom_range(99, 0);
            if (fill && k < 66) beat.mode = xlb_pkg::MODE_INSERT;
            else if (r < 40) beat.mode = xlb_pkg::MODE_INSERT;
            else if (r < 70) beat.mode = xlb_pkg::MODE_QUERY;
            else if (r < 95) beat.mode = xlb_pkg::MODE_MAXIMIZE;
            else beat.mode = xlb_pkg::MODE_CLEAR;
            kind = fill ? 0 : $urandom_range(9, 0);
            if (beat.mode == xlb_pkg::MODE_QUERY && stored_vecs.size() != 0 &&
                $urandom_range(2, 0) != 0) begin
               beat.vec = '0;
               foreach (stored_vecs[n]) if ($urandom_range(1, 0)) beat.vec ^= stored_vecs[n];
            end else begin
               beat.vec = pick_vec(kind);
            end
            if (beat.mode == xlb_pkg::MODE_INSERT) stored_vecs.push_back(beat.vec);
            if (beat.mode == xlb_pkg::MODE_CLEAR) stored_vecs.delete();
            issue_beat(beat, 1'b0, '0);
            sent++;
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
